[rtl/xor_sprite_blitter_assert.svh]
// assertion macros used by the checker file
`ifndef XOR_SPRITE_BLITTER_ASSERT_SVH
`define XOR_SPRITE_BLITTER_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define XSB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent in the next cycle
`define XSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/xsb_pkg.sv]
// shared constants, codes and types of the sprite blitter
package xsb_pkg;

  localparam int DISP_WIDTH  = 64;
  localparam int DISP_HEIGHT = 32;
  localparam int SPRITE_W    = 8;

  localparam int COL_W  = $clog2(DISP_WIDTH);
  localparam int ROW_W  = $clog2(DISP_HEIGHT);
  localparam int LANE_W = $clog2(SPRITE_W);
  localparam int XPOS_W = 8;
  localparam int YPOS_W = 8;
  localparam int RIDX_W = 4;
  localparam int SUM_W  = 9;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef logic [DISP_WIDTH-1:0] row_t;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_data;
    logic             clr;
  } store_req_t;

  typedef struct packed {
    row_t toggle;
    logic hit;
  } lane_out_t;

endpackage

[rtl/xsb_store.sv]
// frame store: row memory with registered read and per-row valid bits
module xsb_store
  import xsb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output row_t       rd_data_o
);

  row_t                   mem_q [DISP_HEIGHT];
  row_t                   rd_data_q;
  logic                   rd_valid_q;
  logic [DISP_HEIGHT-1:0] valid_q;
  logic [DISP_HEIGHT-1:0] valid_d;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // a row never written since reset or the last clear reads as blank
  always_comb begin
    valid_d = valid_q;
    if (req_i.clr) begin
      valid_d = '0;
    end else if (req_i.wr_en) begin
      valid_d[req_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

[rtl/xsb_lane.sv]
// one sprite pixel: wrapped column, toggle mask and collision test
module xsb_lane
  import xsb_pkg::*;
(
  input  logic [XPOS_W-1:0] x_i,
  input  logic [LANE_W-1:0] lane_idx_i,
  input  logic              sprite_bit_i,
  input  row_t              row_i,
  output lane_out_t         out_o
);

  logic [SUM_W-1:0] col_sum;
  logic [COL_W-1:0] col;

  assign col_sum = SUM_W'(x_i) + SUM_W'(lane_idx_i);
  assign col     = COL_W'(col_sum % DISP_WIDTH);

  always_comb begin
    out_o.toggle      = '0;
    out_o.toggle[col] = sprite_bit_i;
    out_o.hit         = sprite_bit_i & row_i[col];
  end

endmodule

[rtl/xsb_merge.sv]
// combines the lane masks into the new row and the lane hits into one flag
module xsb_merge
  import xsb_pkg::*;
(
  input  lane_out_t lanes_i [SPRITE_W],
  input  row_t      row_i,
  output row_t      new_row_o,
  output logic      hit_o
);

  row_t toggle;

  always_comb begin
    toggle = '0;
    hit_o  = 1'b0;
    for (int i = 0; i < SPRITE_W; i++) begin
      toggle = toggle | lanes_i[i].toggle;
      hit_o  = hit_o | lanes_i[i].hit;
    end
  end

  assign new_row_o = row_i ^ toggle;

endmodule

[rtl/xor_sprite_blitter.sv]
// top level of the sprite blitter: sequencer, lanes, merge and frame store
//
// For each command the transaction edge issues the row read of the frame
// store, and in the next cycle eight lanes place the sprite pixels on the
// wrapped columns, the merge stage forms the new row and the collision
// flag, and once the output register is free a drawn row is written back
// as the result enters the output register. The single registered read
// port of the row memory is why the read comes first. A result waiting in
// the output register does not hold back the next command; it only delays
// that command's finish. Clear blanks the whole store at once through
// per-row valid bits, so no clearing pass is needed after reset.
module xor_sprite_blitter
  import xsb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [XPOS_W-1:0] x_pos_i,
  input  logic [YPOS_W-1:0] y_pos_i,
  input  logic [RIDX_W-1:0] row_index_i,
  input  logic [7:0]        row_bits_i,
  input  logic              first_row_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              collision_o,
  output logic              pixel_value_o
);

  state_e            state_q, state_d;
  logic              in_fire;
  logic              exec_done;

  logic [1:0]        cmd_q;
  logic [XPOS_W-1:0] x_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [7:0]        bits_q;
  logic              first_q;

  logic [SUM_W-1:0]  row_sum;
  logic [ROW_W-1:0]  row_addr;

  logic              flag_q, flag_d;
  logic              out_valid_q, out_valid_d;
  logic              collision_q, collision_d;
  logic              pix_q, pix_d;

  store_req_t        store_req;
  row_t              rd_row;
  row_t              new_row;
  logic              hit;
  lane_out_t         lanes [SPRITE_W];

  assign in_fire   = in_valid_i && !in_stall_o;
  assign exec_done = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  // draw adds the sprite row number, read uses the base row only
  assign row_sum  = (cmd_i == CMD_DRAW) ? (SUM_W'(y_pos_i) + SUM_W'(row_index_i))
                                        : SUM_W'(y_pos_i);
  assign row_addr = ROW_W'(row_sum % DISP_HEIGHT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = (state_q != ST_IDLE);
    store_req.rd_en   = in_fire;
    store_req.rd_addr = row_addr;
    store_req.wr_en   = exec_done && (cmd_q == CMD_DRAW);
    store_req.wr_addr = row_q;
    store_req.wr_data = new_row;
    store_req.clr     = exec_done && (cmd_q == CMD_CLEAR);
  end

  always_comb begin
    flag_d      = flag_q;
    collision_d = collision_q;
    pix_d       = pix_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (exec_done) begin
      out_valid_d = 1'b1;
      pix_d       = 1'b0;
      case (cmd_q)
        CMD_DRAW: begin
          flag_d = (flag_q && !first_q) || hit;
        end
        CMD_READ: begin
          pix_d = rd_row[col_q];
        end
        default: ;
      endcase
      collision_d = flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    collision_q <= collision_d;
    pix_q       <= pix_d;
    if (in_fire) begin
      cmd_q   <= cmd_i;
      x_q     <= x_pos_i;
      row_q   <= row_addr;
      col_q   <= COL_W'(x_pos_i % DISP_WIDTH);
      bits_q  <= row_bits_i;
      first_q <= first_row_i;
    end
  end

  xsb_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (rd_row)
  );

  for (genvar g = 0; g < SPRITE_W; g++) begin : g_lane
    // bit 7 of the sprite row is the leftmost pixel
    xsb_lane u_lane (
      .x_i          (x_q),
      .lane_idx_i   (LANE_W'(g)),
      .sprite_bit_i (bits_q[SPRITE_W-1-g]),
      .row_i        (rd_row),
      .out_o        (lanes[g])
    );
  end

  xsb_merge u_merge (
    .lanes_i   (lanes),
    .row_i     (rd_row),
    .new_row_o (new_row),
    .hit_o     (hit)
  );

  assign out_valid_o   = out_valid_q;
  assign collision_o   = collision_q;
  assign pixel_value_o = pix_q;

endmodule

[rtl/xsb_checker.sv]
// port-level checker of the sprite blitter and its bind
`include "xor_sprite_blitter_assert.svh"

module xsb_checker
  import xsb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        cmd_i,
  input logic [XPOS_W-1:0] x_pos_i,
  input logic [YPOS_W-1:0] y_pos_i,
  input logic [RIDX_W-1:0] row_index_i,
  input logic [7:0]        row_bits_i,
  input logic              first_row_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              collision_o,
  input logic              pixel_value_o
);

  logic [2+XPOS_W+YPOS_W+RIDX_W+8:0] in_payload;

  assign in_payload = {cmd_i, x_pos_i, y_pos_i, row_index_i, row_bits_i, first_row_i};

  // a new transaction keeps the input side busy for the following cycle
  `XSB_ASSERT_NEXT(busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after transaction")
  // a result only shows up after a command was in progress
  `XSB_ASSERT_SAME(result_has_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without a command in progress")
  `XSB_ASSERT_NEXT(out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `XSB_ASSERT_NEXT(out_data_holds, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(collision_o) && $stable(pixel_value_o), "result changed while stalled")
  `XSB_ASSERT_NEXT(in_data_holds, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(in_payload), "transaction changed while stalled")

endmodule

bind xor_sprite_blitter xsb_checker u_xsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .cmd_i         (cmd_i),
  .x_pos_i       (x_pos_i),
  .y_pos_i       (y_pos_i),
  .row_index_i   (row_index_i),
  .row_bits_i    (row_bits_i),
  .first_row_i   (first_row_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .collision_o   (collision_o),
  .pixel_value_o (pixel_value_o)
);
